@@ hdl/b64lw_pkg.sv @@
// Shared types, constants and the alphabet function for the base64 line-wrapped encoder.
package b64lw_pkg;

  localparam logic [7:0] NL_CHAR     = 8'h0A;
  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [7:0] WIDTH_RESET = 8'd72;

  // Job queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Character slot in the back end: four symbols then an optional newline
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_LAST_SYM = 3'd3;
  localparam logic [POS_W-1:0] POS_NL       = 3'd4;

  // One group of output characters handed from front to back
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            nl;
  } job_t;

  // Six-bit value to its base64 character
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      sym = 8'h41 + w;
    else if (v < 6'd52) sym = 8'h61 + (w - 8'd26);
    else if (v < 6'd62) sym = 8'h30 + (w - 8'd52);
    else if (v == 6'd62) sym = 8'h2B;
    else                sym = 8'h2F;
  endfunction

endpackage

@@ hdl/b64lw_front.sv @@
// Front end: accepts bytes, gathers groups, tracks the line count and builds jobs.
module b64lw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64lw_pkg::job_t   job_o
);
  import b64lw_pkg::*;

  logic [7:0] width_q;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;
  logic [1:0] gc_q, gc_d;
  logic [7:0] lc_q, lc_d;
  logic [8:0] next_lc;
  logic       wrap;
  logic       fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  // Line count after one more group, compared at nine bits
  assign next_lc = {1'b0, lc_q} + 9'd4;
  assign wrap    = (next_lc >= {1'b0, width_q}) || (next_lc > 9'd255);

  // Group assembly and job build
  always_comb begin
    b0_d   = b0_q;
    b1_d   = b1_q;
    gc_d   = gc_q;
    lc_d   = lc_q;
    push_o = 1'b0;
    job_o  = '0;
    if (fire) begin
      if (gc_q == 2'd2) begin
        push_o       = 1'b1;
        job_o.chars[0] = sym(b0_q[7:2]);
        job_o.chars[1] = sym({b0_q[1:0], b1_q[7:4]});
        job_o.chars[2] = sym({b1_q[3:0], in_byte_i[7:6]});
        job_o.chars[3] = sym(in_byte_i[5:0]);
        job_o.nl     = wrap;
        lc_d         = wrap ? 8'd0 : next_lc[7:0];
        b0_d         = '0;
        b1_d         = '0;
        gc_d         = 2'd0;
      end else if (in_last_i) begin
        push_o = 1'b1;
        if (gc_q == 2'd0) begin
          job_o.chars[0] = sym(in_byte_i[7:2]);
          job_o.chars[1] = sym({in_byte_i[1:0], 4'b0000});
          job_o.chars[2] = PAD_CHAR;
        end else begin
          job_o.chars[0] = sym(b0_q[7:2]);
          job_o.chars[1] = sym({b0_q[1:0], in_byte_i[7:4]});
          job_o.chars[2] = sym({in_byte_i[3:0], 2'b00});
        end
        job_o.chars[3] = PAD_CHAR;
        job_o.nl       = 1'b1;
      end else if (gc_q == 2'd0) begin
        b0_d = in_byte_i;
        b1_d = '0;
        gc_d = 2'd1;
      end else begin
        b1_d = in_byte_i;
        gc_d = 2'd2;
      end
      // End of stream clears the state
      if (in_last_i) begin
        b0_d = '0;
        b1_d = '0;
        gc_d = 2'd0;
        lc_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      b0_q    <= '0;
      b1_q    <= '0;
      gc_q    <= 2'd0;
      lc_q    <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      b0_q <= b0_d;
      b1_q <= b1_d;
      gc_q <= gc_d;
      lc_q <= lc_d;
    end
  end

endmodule

@@ hdl/b64lw_queue.sv @@
// Two-entry job queue between the front and back ends.
module b64lw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64lw_pkg::job_t   job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output b64lw_pkg::job_t   head_o
);
  import b64lw_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hdl/b64lw_back.sv @@
// Back end: sends the characters of the head job one word per cycle while the receiver is ready.
module b64lw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  b64lw_pkg::job_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              out_last_o
);
  import b64lw_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             fire;

  assign out_valid_o = !empty_i;
  assign fire        = out_valid_o && out_ready_i;

  // Character select and end-of-job flag
  always_comb begin
    if (pos_q == POS_NL) out_char_o = NL_CHAR;
    else                 out_char_o = head_i.chars[pos_q[1:0]];
    out_last_o = (pos_q == POS_NL) || ((pos_q == POS_LAST_SYM) && !head_i.nl);
  end

  assign pop_o = fire && out_last_o;

  always_comb begin
    pos_d = pos_q;
    if (fire) begin
      pos_d = out_last_o ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ hdl/base64_line_wrapped_encoder.sv @@
// Top level of the base64 encoder with line wrapping.
// A byte that completes or ends a group shows its first character on the
//   next cycle when the job queue was empty; the four or five characters then leave
//   one per cycle while the receiver is ready.
// Throughput: one byte per cycle is taken while the two-entry job queue has room;
//   sustained rate is set by the back end.
// Reset (rst_ni low, asynchronous): queue empty, group and line state cleared,
//   line width back to 72.
module base64_line_wrapped_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_data
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // run_last
);
  import b64lw_pkg::*;

  job_t job, head;
  logic push, pop, q_full, q_empty;

  b64lw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job)
  );

  b64lw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  b64lw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // A job is never offered to a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // A newline only ever closes a job
  a_nl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata == NL_CHAR) |-> m_axis_tlast)
    else $error("newline not at end of job");

  // Padding never ends a job: a second pad or the newline always follows it
  a_pad_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata == PAD_CHAR) |-> !m_axis_tlast)
    else $error("padding marked as last word");

endmodule

@@ bench/b64lw_checker.sv @@
// Checker for the base64 line-wrapped encoder: predicts every output character and compares.
module b64lw_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_data
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_char
  input  logic       m_axis_tlast,   // run_last
  output int         mismatches,
  output int         chars_due
);
  import b64lw_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  string b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Predicted character stream, oldest first
  enc_char_t  due_q[$];

  // Shadow of the encoder state and its width register
  logic [7:0] line_width;
  logic [7:0] held_hi;
  logic [7:0] held_lo;
  logic [1:0] grp_cnt;
  logic [7:0] line_cnt;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    b64_char = b64_set[v];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Works out the characters one input word causes and updates the shadow state
  task automatic encode_word(input logic [7:0] b, input logic fin);
    logic [7:0] chars[$];
    logic [8:0] nxt;
    chars = {};
    if (grp_cnt == 2'd2) begin
      chars.push_back(b64_char(held_hi[7:2]));
      chars.push_back(b64_char({held_hi[1:0], held_lo[7:4]}));
      chars.push_back(b64_char({held_lo[3:0], b[7:6]}));
      chars.push_back(b64_char(b[5:0]));
      // line length compared at nine bits so it never wraps
      nxt = {1'b0, line_cnt} + 9'd4;
      if (nxt >= {1'b0, line_width} || nxt > 9'd255) begin
        chars.push_back(NL_CHAR);
        line_cnt = 8'd0;
      end else begin
        line_cnt = nxt[7:0];
      end
      held_hi = 8'd0;
      held_lo = 8'd0;
      grp_cnt = 2'd0;
    end else if (fin) begin
      // partial group: pad to four, always end the line
      if (grp_cnt == 2'd0) begin
        chars.push_back(b64_char(b[7:2]));
        chars.push_back(b64_char({b[1:0], 4'b0000}));
        chars.push_back(PAD_CHAR);
      end else begin
        chars.push_back(b64_char(held_hi[7:2]));
        chars.push_back(b64_char({held_hi[1:0], b[7:4]}));
        chars.push_back(b64_char({b[3:0], 2'b00}));
      end
      chars.push_back(PAD_CHAR);
      chars.push_back(NL_CHAR);
    end else if (grp_cnt == 2'd0) begin
      held_hi = b;
      grp_cnt = 2'd1;
    end else begin
      held_lo = b;
      grp_cnt = 2'd2;
    end

    // end of stream clears the state, width stays
    if (fin) begin
      held_hi  = 8'd0;
      held_lo  = 8'd0;
      grp_cnt  = 2'd0;
      line_cnt = 8'd0;
    end

    foreach (chars[i]) due_q.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q      = {};
      line_width = WIDTH_RESET;
      held_hi    = 8'd0;
      held_lo    = 8'd0;
      grp_cnt    = 2'd0;
      line_cnt   = 8'd0;
      mismatches = 0;
      chars_due  = 0;
    end else begin
      if (cfg_we_i) line_width = cfg_wdata_i;

      // output side first: a word accepted now cannot show up on this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          enc_char_t exp_c;
          exp_c = due_q.pop_front();
          if (m_axis_tdata !== exp_c.ch)
            report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                      m_axis_tdata, exp_c.ch));
          if (m_axis_tlast !== exp_c.last)
            report_mismatch($sformatf("run_last %0b, want %0b on char 0x%02h",
                                      m_axis_tlast, exp_c.last, exp_c.ch));
        end
      end

      if (s_axis_tvalid && s_axis_tready) encode_word(s_axis_tdata, s_axis_tlast);

      chars_due = due_q.size();
    end
  end

endmodule

@@ bench/tb_base64_line_wrapped_encoder.sv @@
// Testbench top for the base64 line-wrapped encoder: stimulus, flow control and verdict.
module tb_base64_line_wrapped_encoder;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER  = 40;    // input words before the long receiver hold
  localparam int HOLD_CYCLES = 120;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [7:0] cfg_wdata_i   = 8'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;   // [7:0] data_byte
  logic       s_axis_tlast  = 1'b0;   // end_of_data
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_char
  logic       m_axis_tlast;           // run_last

  int mismatches;
  int chars_due;
  int cycles    = 0;
  int in_words  = 0;
  int hold_cnt  = 0;
  bit hold_done = 1'b0;
  int rx_mode   = 0;
  int mode_left = 0;
  int burst_left = 0;

  always #5 clk_i = ~clk_i;

  base64_line_wrapped_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  b64lw_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .mismatches   (mismatches),
    .chars_due    (chars_due)
  );

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_words <= in_words + 1;
  end

  // Receiver: modes of free flow, light and heavy stalls, plus one long hold
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && in_words >= HOLD_AFTER) begin
      hold_done     <= 1'b1;
      hold_cnt      <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one word and waits for it to be taken; bursts separated by random gaps, sometimes none
  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic send_stream(input logic [7:0] bytes[$], input logic fin);
    foreach (bytes[i]) send_word(bytes[i], fin && (i == bytes.size() - 1));
  endtask

  // Waits for the encoder to drain, then writes the line width
  task automatic set_line_width(input logic [7:0] w);
    s_axis_tvalid <= 1'b0;
    while (chars_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random streams; each word may end a stream, the phase may end mid-stream
  task automatic random_phase(input logic [7:0] w, input int n_words);
    logic fin;
    set_line_width(w);
    for (int i = 0; i < n_words; i++) begin
      if (i == n_words - 1) fin = 1'($urandom_range(0, 1));
      else fin = ($urandom_range(0, 7) == 0);
      send_word(8'($urandom_range(0, 255)), fin);
    end
  endtask

  initial begin
    logic [7:0] widths[$];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset width: one- and two-byte tails, final full group, alphabet ends
    send_stream({8'h00}, 1'b1);
    send_stream({8'hFF, 8'hFE}, 1'b1);
    send_stream({8'h00, 8'h10, 8'h83}, 1'b1);
    send_stream({8'hFB, 8'hEF, 8'hBE, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    send_stream({8'h80}, 1'b1);

    // Narrow width: newline after every group
    set_line_width(8'd4);
    send_stream({8'h4D, 8'h61, 8'h6E, 8'h7F, 8'h01}, 1'b1);

    // Width not a multiple of four
    set_line_width(8'd6);
    send_stream({8'h12, 8'h34, 8'h56, 8'hA9, 8'hCB, 8'hED, 8'h55}, 1'b1);

    // Random phases across widths, extremes included
    widths = {8'd5, 8'd0, 8'd1, 8'd252, 8'd3, 8'd4, 8'd253, 8'd8,
              8'($urandom_range(4, 252)), 8'd254, 8'd12};
    foreach (widths[i]) random_phase(widths[i], 16);

    // Long stream at the widest width: the line caps at 256 characters
    set_line_width(8'd255);
    for (int i = 0; i < 195; i++) send_word(8'($urandom_range(0, 255)), i == 194);

    set_line_width(8'd72);
    random_phase(8'($urandom_range(4, 252)), 10);

    s_axis_tvalid <= 1'b0;
    while (chars_due != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && chars_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
